// ===== rtl/core/clsr_pkg.sv =====
package clsr_pkg;

  // Shuffle table geometry.
  localparam int TABLE_SIZE = 32;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 8);

  // Warm-up runs TABLE_SIZE + 8 steps; the counter walks down to zero.
  localparam logic [CNT_W-1:0] WARM_LAST   = CNT_W'(TABLE_SIZE + 7);
  localparam logic [CNT_W-1:0] TABLE_LIMIT = CNT_W'(TABLE_SIZE);

  // Operation codes carried by a request transaction.
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // Generator constants.
  localparam logic [31:0] MOD_A = 32'd2147483563;
  localparam logic [31:0] MOD_B = 32'd2147483399;
  localparam logic [15:0] MUL_A = 16'd40014;
  localparam logic [15:0] MUL_B = 16'd40692;

  // 2^31 mod m for each modulus, used to fold the high part of a product.
  localparam logic [7:0] FOLD_A = 8'(32'h8000_0000 - MOD_A);
  localparam logic [7:0] FOLD_B = 8'(32'h8000_0000 - MOD_B);

  localparam logic [30:0] TOP_VALUE = 31'd2147483562;
  localparam logic [30:0] SEED_MAX  = 31'd2147483562;

  // Reset values.
  localparam logic [30:0] G1_RESET         = 31'd1;
  localparam logic [30:0] G2_RESET         = 31'd123456789;
  localparam logic [30:0] START_SEED_RESET = 31'd237;

  // Slot selection: slot = last / SLOT_DIV, done as a multiply by a
  // reciprocal followed by a single correction step.
  localparam longint     SLOT_DIV_L = 1 + 2147483562 / TABLE_SIZE;
  localparam logic [31:0] SLOT_DIV  = 32'(SLOT_DIV_L);
  localparam longint     RECIP_L    = (longint'(1) <<< 32) / SLOT_DIV_L;
  localparam int         RECIP_W    = $clog2(RECIP_L + 1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int         QPROD_W    = 31 + RECIP_W;
  localparam int         QEST_W     = QPROD_W - 32;
  localparam logic [31:0] SLOT_TOP  = 32'(TABLE_SIZE - 1);

  // Configuration register map.
  localparam logic [1:0] ADDR_START_SEED = 2'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WARM_MUL,
    ST_WARM_FOLD,
    ST_DRAW_MUL,
    ST_DRAW_FOLD,
    ST_DRAW_READ,
    ST_DRAW_OUT
  } clsr_state_t;

  typedef struct packed {
    logic load_seed;
    logic warm_mul;
    logic warm_fold;
    logic draw_mul;
    logic draw_fold;
    logic draw_read;
    logic commit;
  } clsr_cmd_t;

  typedef struct packed {
    logic warm_done;
    logic res_free;
  } clsr_status_t;

  // Reduces a 47-bit product modulo m, where m = 2^31 - fold_c.
  // The folded sum stays below 2m, so one conditional subtract finishes it.
  function automatic logic [30:0] lcg_fold(input logic [46:0] prod,
                                           input logic [31:0] modulus,
                                           input logic [7:0]  fold_c);
    logic [15:0] hi;
    logic [30:0] lo;
    logic [23:0] hc;
    logic [31:0] t;
    hi = prod[46:31];
    lo = prod[30:0];
    hc = hi * fold_c;
    t  = {1'b0, lo} + {8'd0, hc};
    if (t >= modulus) begin
      t = t - modulus;
    end
    return t[30:0];
  endfunction

  // Seeds above range saturate, and a zero seed becomes one.
  function automatic logic [30:0] seed_clamp(input logic [30:0] seed);
    logic [30:0] s;
    s = (seed > SEED_MAX) ? SEED_MAX : seed;
    if (s == 31'd0) begin
      s = 31'd1;
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/combined_lcg_shuffle_rng.sv =====
// A draw transaction steps through the multiply, fold, table read and output
// states; a reseed transaction first runs TABLE_SIZE + 8 warm-up steps, each
// a multiply and a fold. A new request is taken only once the block is back
// in idle, after the shared multiply and fold step, the table read and the
// write-back on one memory port, which waits for the output to be free.
// Reset (synchronous, active high) restores start_seed to 237 and arms a reseed.
module combined_lcg_shuffle_rng (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel.
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        operation,
  input  logic [30:0] seed_value,
  // Result channel.
  output logic        result_valid,
  input  logic        result_ready,
  output logic [30:0] random_value
);
  import clsr_pkg::*;

  logic [30:0]  start_seed;
  clsr_cmd_t    cmd;
  clsr_status_t status;

  // The start seed register sits behind the configuration port. It is only
  // consulted by the first transaction after reset, and only when that
  // transaction does not bring a seed of its own.
  clsr_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .start_seed (start_seed)
  );

  // The controller sequences each transaction: an optional warm-up loop that
  // steps the first generator and fills the shuffle table from the top slot
  // down, then the draw itself. It also remembers whether a reseed is still
  // owed since reset.
  clsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .operation  (operation),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds both generators, the shuffle table memory and the
  // output register. Each generator step is a registered multiply followed
  // by a fold modulo a prime just below 2^31. The output register lets a new
  // transaction be accepted while the previous result is still waiting to
  // be taken; only the final write-back waits for the output to be free.
  clsr_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (operation),
    .seed_value   (seed_value),
    .start_seed   (start_seed),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .random_value (random_value)
  );

endmodule

// ===== rtl/core/clsr_regs.sv =====
module clsr_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [30:0] start_seed
);
  import clsr_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_START_SEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_seed <= START_SEED_RESET;
    end else if (wr_en) begin
      start_seed <= pwdata[30:0];
    end
  end

  assign prdata = (paddr == ADDR_START_SEED) ? {1'b0, start_seed} : 32'd0;

endmodule

// ===== rtl/core/clsr_ctrl.sv =====
module clsr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   operation,
  output logic                   item_ready,
  input  clsr_pkg::clsr_status_t status,
  output clsr_pkg::clsr_cmd_t    cmd
);
  import clsr_pkg::*;

  clsr_state_t state;
  clsr_state_t state_next;
  logic        pending;
  logic        reseed;

  // Pending seed forces a reseed on the first transaction after reset.
  assign reseed = (operation == OP_RESEED) || pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b1;
    end else begin
      state <= state_next;
      if (item_valid && item_ready) begin
        pending <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = reseed ? ST_WARM_MUL : ST_DRAW_MUL;
        end
      end
      ST_WARM_MUL:  state_next = ST_WARM_FOLD;
      ST_WARM_FOLD: state_next = status.warm_done ? ST_DRAW_MUL : ST_WARM_MUL;
      ST_DRAW_MUL:  state_next = ST_DRAW_FOLD;
      ST_DRAW_FOLD: state_next = ST_DRAW_READ;
      ST_DRAW_READ: state_next = ST_DRAW_OUT;
      ST_DRAW_OUT: begin
        if (status.res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready    = 1'b1;
        cmd.load_seed = item_valid && reseed;
      end
      ST_WARM_MUL:  cmd.warm_mul  = 1'b1;
      ST_WARM_FOLD: cmd.warm_fold = 1'b1;
      ST_DRAW_MUL:  cmd.draw_mul  = 1'b1;
      ST_DRAW_FOLD: cmd.draw_fold = 1'b1;
      ST_DRAW_READ: cmd.draw_read = 1'b1;
      ST_DRAW_OUT:  cmd.commit    = status.res_free;
      default: begin
        cmd        = '0;
        item_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/clsr_dpath.sv =====
module clsr_dpath (
  input  logic                   clk,
  input  logic                   rst,
  input  clsr_pkg::clsr_cmd_t    cmd,
  output clsr_pkg::clsr_status_t status,
  input  logic                   operation,
  input  logic [30:0]            seed_value,
  input  logic [30:0]            start_seed,
  input  logic                   result_ready,
  output logic                   result_valid,
  output logic [30:0]            random_value
);
  import clsr_pkg::*;

  logic [30:0]        g1;
  logic [30:0]        g2;
  logic [30:0]        last;
  logic [CNT_W-1:0]   count;
  logic [46:0]        prod_a;
  logic [46:0]        prod_b;
  logic [QPROD_W-1:0] qprod;
  logic [SLOT_W-1:0]  slot;
  logic [30:0]        rd_data;
  logic [30:0]        table_mem [TABLE_SIZE];

  logic [30:0]        seed_c;
  logic [30:0]        fold_a;
  logic [30:0]        fold_b;
  logic [QEST_W-1:0]  q_est;
  logic [31:0]        qd;
  logic [31:0]        rem;
  logic [31:0]        q_full;
  logic [SLOT_W-1:0]  slot_c;
  logic [31:0]        diff;
  logic [31:0]        lifted;
  logic [30:0]        y;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_addr;
  logic [30:0]        mem_wdata;

  assign seed_c = seed_clamp((operation == OP_RESEED) ? seed_value : start_seed);
  assign fold_a = lcg_fold(prod_a, MOD_A, FOLD_A);
  assign fold_b = lcg_fold(prod_b, MOD_B, FOLD_B);

  // Reciprocal estimate is low by at most one; a single compare fixes it.
  always_comb begin
    q_est  = qprod[QPROD_W-1:32];
    qd     = {{(32-QEST_W){1'b0}}, q_est} * SLOT_DIV;
    rem    = {1'b0, last} - qd;
    q_full = {{(32-QEST_W){1'b0}}, q_est} + {31'd0, (rem >= SLOT_DIV)};
    slot_c = (q_full > SLOT_TOP) ? SLOT_TOP[SLOT_W-1:0] : q_full[SLOT_W-1:0];
  end

  always_comb begin
    diff   = {1'b0, rd_data} - {1'b0, g2};
    lifted = diff + {1'b0, TOP_VALUE};
    y      = (diff[31] || (diff == 32'd0)) ? lifted[30:0] : diff[30:0];
  end

  assign status.warm_done = (count == '0);
  assign status.res_free  = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      g1           <= G1_RESET;
      g2           <= G2_RESET;
      last         <= 31'd0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.load_seed) begin
        g1    <= seed_c;
        g2    <= seed_c;
        count <= WARM_LAST;
      end
      if (cmd.warm_fold) begin
        g1    <= fold_a;
        last  <= fold_a;
        count <= count - 1'b1;
      end
      if (cmd.draw_fold) begin
        g1 <= fold_a;
        g2 <= fold_b;
      end
      if (cmd.commit) begin
        last         <= y;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.warm_mul || cmd.draw_mul) begin
      prod_a <= {16'd0, g1} * {31'd0, MUL_A};
    end
    if (cmd.draw_mul) begin
      prod_b <= {16'd0, g2} * {31'd0, MUL_B};
      qprod  <= {{RECIP_W{1'b0}}, last} * {31'd0, RECIP};
    end
    if (cmd.draw_fold) begin
      slot <= slot_c;
    end
    if (cmd.commit) begin
      random_value <= y;
    end
  end

  assign mem_we    = (cmd.warm_fold && (count < TABLE_LIMIT)) || cmd.commit;
  assign mem_addr  = cmd.commit ? slot : count[SLOT_W-1:0];
  assign mem_wdata = cmd.commit ? g1 : fold_a;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    if (cmd.draw_read) begin
      rd_data <= table_mem[slot];
    end
  end

endmodule

// ===== rtl/core/clsr_checker.sv =====
module clsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [30:0] random_value
);
  import clsr_pkg::*;

  // Every result lies in 1..TOP_VALUE.
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (random_value != 31'd0) && (random_value <= TOP_VALUE))
    else $error("result outside 1..TOP_VALUE");

  // An accepted transaction keeps the block busy for at least the draw steps.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready ##1 !item_ready ##1 !item_ready)
    else $error("request accepted again before the draw finished");

  // A new result only appears at the end of a transaction.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared without a transaction in flight");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid && $stable(random_value))
    else $error("stalled result changed");

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .random_value (random_value)
);

// ===== bench/tb_combined_lcg_shuffle_rng.sv =====
module tb_combined_lcg_shuffle_rng;
  import clsr_pkg::*;

  // Generator constants for the predictor. Products stay below 2^47, so a
  // plain 64-bit multiply and modulo gives the same values as a Schrage step.
  localparam longint GEN1_MOD  = 64'd2147483563;
  localparam longint GEN2_MOD  = 64'd2147483399;
  localparam longint GEN1_MUL  = 64'd40014;
  localparam longint GEN2_MUL  = 64'd40692;
  localparam longint OUT_TOP   = GEN1_MOD - 1;
  localparam longint SLOT_SPAN = 1 + OUT_TOP / TABLE_SIZE;
  localparam logic [30:0] SEED_CEIL = 31'd2147483562;

  // The tail wait covers a whole reseed transaction with margin.
  localparam int TAIL_CYCLES = 120;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 660;

  typedef struct packed {
    logic        op;
    logic [30:0] seed;
  } rng_request_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [1:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  logic        operation    = OP_DRAW;
  logic [30:0] seed_value   = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [30:0] random_value;

  combined_lcg_shuffle_rng dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operation    (operation),
    .seed_value   (seed_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .random_value (random_value)
  );

  always #10 clk = ~clk;

  // Requests waiting to be driven, and the values that the predictor says
  // the accepted requests must produce, oldest first.
  rng_request_t pending_requests[$];
  logic [30:0]  expected_values[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Predictor state: the start seed register, both generators, the last
  // output, the shuffle table and the flag that arms the automatic reseed.
  logic [30:0] start_seed_copy;
  longint      gen1_state;
  longint      gen2_state;
  longint      last_draw;
  longint      shuffle_slots[TABLE_SIZE];
  bit          seed_armed;

  task automatic report_mismatch(input string what, input longint got,
                                 input longint want);
    $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Loads both generators from the (clamped) seed and runs the warm-up; the
  // last TABLE_SIZE steps fill the table from the top slot downwards.
  task automatic warm_up_table(input logic [30:0] seed);
    longint s;
    s = (seed > SEED_CEIL) ? longint'(SEED_CEIL) : longint'(seed);
    if (s == 0) begin
      s = 1;
    end
    gen2_state = s;
    for (int i = TABLE_SIZE + 7; i >= 0; i--) begin
      s = (s * GEN1_MUL) % GEN1_MOD;
      if (i < TABLE_SIZE) begin
        shuffle_slots[i] = s;
      end
    end
    gen1_state = s;
    last_draw  = shuffle_slots[0];
  endtask

  // Works out the value that one accepted request produces and advances the
  // predictor state accordingly.
  task automatic next_random_value(input logic op, input logic [30:0] seed,
                                   output logic [30:0] value);
    longint slot;
    longint y;
    if (op == OP_RESEED) begin
      warm_up_table(seed);
      seed_armed = 1'b0;
    end else if (seed_armed) begin
      warm_up_table(start_seed_copy);
      seed_armed = 1'b0;
    end
    gen1_state = (gen1_state * GEN1_MUL) % GEN1_MOD;
    gen2_state = (gen2_state * GEN2_MUL) % GEN2_MOD;
    slot = last_draw / SLOT_SPAN;
    if (slot > TABLE_SIZE - 1) begin
      slot = TABLE_SIZE - 1;
    end
    y = shuffle_slots[slot] - gen2_state;
    shuffle_slots[slot] = gen1_state;
    if (y < 1) begin
      y += OUT_TOP;
    end
    last_draw = y;
    value = y[30:0];
  endtask

  // Seeds lean towards the edges: zero, one, the top of the range, values
  // above it that must saturate, and the second modulus, which parks the
  // second generator at zero.
  function automatic logic [30:0] pick_seed();
    case ($urandom_range(11))
      0: return 31'd0;
      1: return 31'd1;
      2: return SEED_CEIL;
      3: return 31'h7FFF_FFFF;
      4: return SEED_CEIL + 31'($urandom_range(1, 85));
      5: return 31'(GEN2_MOD) + 31'($urandom_range(0, 3)) - 31'd1;
      6: return 31'($urandom_range(1, 1000));
      default: return 31'($urandom());
    endcase
  endfunction

  task automatic queue_request(input logic op, input logic [30:0] seed);
    rng_request_t r;
    r.op   = op;
    r.seed = seed;
    pending_requests.push_back(r);
  endtask

  // Mostly draws, with a reseed now and then; the seed field of a draw is
  // random as well, since the block must ignore it.
  task automatic queue_random_requests(input int count);
    for (int n = 0; n < count; n++) begin
      queue_request(($urandom_range(9) == 0) ? OP_RESEED : OP_DRAW, pick_seed());
    end
  endtask

  // Returns once nothing is queued, nothing is being offered and every
  // expected result has been taken. Sampled at the falling edge, after all
  // updates of the rising edge have settled.
  task automatic wait_until_quiet();
    do @(negedge clk);
    while (pending_requests.size() != 0 || item_valid || expected_values.size() != 0);
  endtask

  // Write of the start seed register: a setup cycle, then the access cycle,
  // which completes at the edge at which pready is seen high.
  task automatic write_start_seed(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_START_SEED;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    start_seed_copy = value[30:0];
  endtask

  // Driver: offers the next queued request when the channel is free. A
  // request that has been offered is held, unchanged, until it is
  // accepted.
  always @(posedge clk) begin
    rng_request_t r;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        r = pending_requests.pop_front();
        item_valid <= 1'b1;
        operation  <= r.op;
        seed_value <= r.seed;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted
  // result. Both happen in this one block, so their order within an edge is
  // fixed. It also drives the result side's ready with random stalls.
  always @(posedge clk) begin
    logic [30:0] want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        next_random_value(operation, seed_value, want);
        expected_values.push_back(want);
      end
      if (result_valid && result_ready) begin
        if (expected_values.size() == 0) begin
          report_mismatch("random_value with nothing outstanding", random_value, 0);
        end else begin
          want = expected_values.pop_front();
          if (random_value !== want) begin
            report_mismatch("random_value", random_value, want);
          end
        end
      end
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] first_seed;

    // The predictor starts from the block's reset state.
    start_seed_copy = START_SEED_RESET;
    gen1_state      = 1;
    gen2_state      = 123456789;
    last_draw       = 0;
    seed_armed      = 1'b1;
    foreach (shuffle_slots[i]) shuffle_slots[i] = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Two writes before the first draw: only the second must take effect.
    // Bit 31 of the write data lies outside the register: one in the first write, random in the second.
    write_start_seed({1'b1, 31'h7FFF_FFFF});
    case ($urandom_range(4))
      0: first_seed = {1'($urandom()), 31'd0};
      1: first_seed = {1'($urandom()), SEED_CEIL};
      2: first_seed = {1'($urandom()), 31'h7FFF_FFFF};
      default: first_seed = $urandom();
    endcase
    write_start_seed(first_seed);

    // Directed part, with the sender idling a third of the time and the
    // receiver two thirds. The first draw seeds itself from the register.
    send_idle_pct = 34;
    recv_idle_pct = 64;
    queue_request(OP_DRAW,   31'h7FFF_FFFF);
    queue_request(OP_DRAW,   31'd0);
    queue_request(OP_RESEED, 31'd0);
    queue_request(OP_DRAW,   31'h2AAA_AAAA);
    queue_request(OP_RESEED, 31'd1);
    queue_request(OP_DRAW,   31'h5555_5555);
    queue_request(OP_RESEED, SEED_CEIL);
    queue_request(OP_DRAW,   31'd0);
    queue_request(OP_DRAW,   31'd0);
    queue_request(OP_RESEED, 31'h7FFF_FFFF);
    queue_request(OP_DRAW,   31'd0);
    queue_request(OP_RESEED, 31'(GEN2_MOD));
    queue_request(OP_DRAW,   31'd0);
    queue_request(OP_DRAW,   31'd0);
    queue_request(OP_DRAW,   31'd0);
    queue_request(OP_RESEED, 31'(GEN2_MOD) + 31'd1);
    queue_request(OP_DRAW,   31'd0);
    queue_request(OP_RESEED, 31'h5555_5555);
    queue_request(OP_RESEED, 31'h2AAA_AAAA);
    queue_request(OP_DRAW,   31'h7FFF_FFFF);

    // The sender holds off here until every result has come back; the
    // register is then rewritten, which no longer affects the sequence.
    wait_until_quiet();
    write_start_seed(32'd0);
    queue_random_requests(PHASE_ITEMS);

    wait_until_quiet();
    write_start_seed({1'b0, SEED_CEIL});
    send_idle_pct = 64;
    recv_idle_pct = 34;
    queue_random_requests(PHASE_ITEMS);

    wait_until_quiet();
    write_start_seed($urandom());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_requests(PHASE_ITEMS);

    wait_until_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_values.size() != 0) begin
      report_mismatch("results still outstanding", 0, expected_values.size());
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
